### hw/rtl/prtt_pkg.sv
// Shared constants, codes and cell control types for the pending request timeout tracker.
package prtt_pkg;

    localparam int NUM_ENTRIES    = 32;
    localparam int MAX_PER_CLIENT = 16;
    localparam int IDX_W          = $clog2(NUM_ENTRIES);
    localparam int CNT_W          = 6;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_FINISH = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_FINISH  = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_QUERY   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_TOO_MANY = 2'd2
    } status_t;

    localparam logic REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic        alloc;
        logic        drop_tent;
        logic        commit;
        logic        tick;
        logic        find;
        logic        drain;
        logic        grp_active;
        logic [15:0] grp_tag;
        logic [7:0]  client;
        logic [63:0] ident;
        logic [15:0] batch;
        logic [31:0] timeout;
    } cell_ctl_t;

    typedef struct packed {
        logic        pending;
        logic        owner_hit;
        logic        id_hit;
        logic        pend_owner;
        logic        pend_hit;
        logic        expired;
        logic        tag_hit;
        logic        sel;
        logic [7:0]  owner;
        logic [63:0] ident;
        logic [15:0] batch;
    } cell_stat_t;

endpackage

### hw/rtl/prtt_if.sv
// Request and result channel interfaces.
interface prtt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [7:0]         client;
    logic signed [63:0] request_id;
    logic               last;

    modport source (output valid, mode, client, request_id, last, input ready);
    modport sink (input valid, mode, client, request_id, last, output ready);
    modport monitor (input valid, ready, mode, client, request_id, last);
endinterface

interface prtt_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         status;
    logic signed [63:0] request_id_res;
    logic [7:0]         client_res;
    logic [15:0]        batch_tag;
    logic               found;
    logic [5:0]         client_count;
    logic [5:0]         total_count;
    logic               end_of_group;

    modport source (output valid, kind, status, request_id_res, client_res, batch_tag, found,
                    client_count, total_count, end_of_group, input ready);
    modport sink (input valid, kind, status, request_id_res, client_res, batch_tag, found,
                  client_count, total_count, end_of_group, output ready);
    modport monitor (input valid, ready, kind, status, request_id_res, client_res, batch_tag,
                     found, client_count, total_count, end_of_group);
endinterface

### hw/rtl/prtt_cell.sv
// One table entry; passes free and pick tokens to the next cell.
module prtt_cell
    import prtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic [15:0] sel_tag,
    input  logic       free_in,
    output logic       free_out,
    input  logic       take_in,
    output logic       take_out,
    output cell_stat_t stat
);

    logic        valid_reg, valid_next;
    logic        tent_reg, tent_next;
    logic        exp_reg, exp_next;
    logic [7:0]  owner_reg;
    logic [63:0] ident_reg;
    logic [15:0] batch_reg;
    logic [31:0] dl_reg, dl_next;
    logic        alloc_here;
    logic        pending;
    logic        cand;
    logic        sel;

    always_comb
    begin
        pending    = valid_reg && !tent_reg;
        free_out   = free_in || !valid_reg;
        alloc_here = ctl.alloc && !valid_reg && !free_in;
        cand       = (ctl.find && pending && owner_reg == ctl.client && ident_reg == ctl.ident)
                  || (ctl.drain && exp_reg && (!ctl.grp_active || batch_reg == ctl.grp_tag));
        sel        = cand && !take_in;
        take_out   = take_in || cand;

        stat.pending    = pending;
        stat.owner_hit  = valid_reg && owner_reg == ctl.client;
        stat.id_hit     = stat.owner_hit && ident_reg == ctl.ident;
        stat.pend_owner = pending && stat.owner_hit;
        stat.pend_hit   = pending && stat.id_hit;
        stat.expired    = exp_reg;
        stat.tag_hit    = exp_reg && batch_reg == sel_tag;
        stat.sel        = sel;
        stat.owner      = sel ? owner_reg : 8'd0;
        stat.ident      = sel ? ident_reg : 64'd0;
        stat.batch      = sel ? batch_reg : 16'd0;

        valid_next = valid_reg;
        tent_next  = tent_reg;
        exp_next   = exp_reg;
        dl_next    = dl_reg;
        if (alloc_here)
        begin
            valid_next = 1'b1;
            tent_next  = !ctl.commit;
            exp_next   = 1'b0;
            dl_next    = ctl.commit ? ctl.timeout : 32'd0;
        end
        else if (sel)
        begin
            valid_next = 1'b0;
            exp_next   = 1'b0;
        end
        else if (tent_reg && ctl.drop_tent)
        begin
            valid_next = 1'b0;
            tent_next  = 1'b0;
        end
        else if (tent_reg && ctl.commit)
        begin
            tent_next = 1'b0;
            dl_next   = ctl.timeout;
        end
        else if (ctl.tick && pending)
        begin
            if (dl_reg == 32'd0)
                exp_next = 1'b1;
            else
                dl_next = dl_reg - 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tent_reg  <= 1'b0;
            exp_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tent_reg  <= tent_next;
            exp_reg   <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg <= dl_next;
        if (alloc_here)
        begin
            owner_reg <= ctl.client;
            ident_reg <= ctl.ident;
            batch_reg <= ctl.batch;
        end
    end

endmodule

### hw/rtl/pending_request_timeout_tracker_unit.sv
// Top level: request FSM, chain of entry cells, result register and APB register.
//
//  channel  dir  handshake       contents
//  req      in   valid/ready     mode, client, request_id, last
//  res      out  valid/ready     kind, status, ids, counts, end_of_group
//  apb      in   psel/penable    timeout_ticks at offset 0
//
// One request at a time: accept, then execute against the cell row.
// A tick then drains one timed-out ID per cycle while the output register is free.
// Any result waits in the output register; a full register stalls the sequencer.
// Reset empties the table at once; no clearing pass.
module pending_request_timeout_tracker_unit
    import prtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    prtt_req_if.sink    req,
    prtt_res_if.source  res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] timeout_reg;
    logic [15:0] next_batch_reg, next_batch_next;
    logic [1:0]  open_reg, open_next;
    logic        grp_active_reg, grp_active_next;
    logic [15:0] grp_tag_reg, grp_tag_next;

    mode_t       mode_reg;
    logic [7:0]  client_reg;
    logic [63:0] ident_reg;
    logic        last_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [63:0] out_id_reg, out_id_next;
    logic [7:0]  out_client_reg, out_client_next;
    logic [15:0] out_tag_reg, out_tag_next;
    logic        out_found_reg, out_found_next;
    logic [5:0]  out_cc_reg, out_cc_next;
    logic [5:0]  out_tc_reg, out_tc_next;
    logic        out_eog_reg, out_eog_next;

    cell_ctl_t   ctl;
    cell_stat_t  stat [NUM_ENTRIES];
    logic        free_chain [NUM_ENTRIES+1];
    logic        take_chain [NUM_ENTRIES+1];

    logic [NUM_ENTRIES-1:0] pend_v, owner_v, idhit_v, pown_v, phit_v, exp_v, tag_v, sel_v;
    logic [7:0]  sel_owner;
    logic [63:0] sel_ident;
    logic [15:0] sel_tag;
    logic [CNT_W-1:0] used_cnt;
    logic        out_free;
    logic        eog;
    logic [1:0]  st_new;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= 32'd1000;
        else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
            timeout_reg <= pwdata;
    end

    assign free_chain[0] = 1'b0;
    assign take_chain[0] = 1'b0;

    for (genvar g = 0; g < NUM_ENTRIES; g++)
    begin : g_cell
        prtt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .sel_tag  (sel_tag),
            .free_in  (free_chain[g]),
            .free_out (free_chain[g+1]),
            .take_in  (take_chain[g]),
            .take_out (take_chain[g+1]),
            .stat     (stat[g])
        );
    end

    always_comb
    begin
        sel_owner = 8'd0;
        sel_ident = 64'd0;
        sel_tag   = 16'd0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            pend_v[i]  = stat[i].pending;
            owner_v[i] = stat[i].owner_hit;
            idhit_v[i] = stat[i].id_hit;
            pown_v[i]  = stat[i].pend_owner;
            phit_v[i]  = stat[i].pend_hit;
            exp_v[i]   = stat[i].expired;
            tag_v[i]   = stat[i].tag_hit;
            sel_v[i]   = stat[i].sel;
            sel_owner  = sel_owner | stat[i].owner;
            sel_ident  = sel_ident | stat[i].ident;
            sel_tag    = sel_tag | stat[i].batch;
        end
    end

    assign used_cnt = CNT_W'($countones(owner_v));
    assign eog      = ((tag_v & ~sel_v) == '0);
    assign out_free = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        next_batch_next = next_batch_reg;
        open_next       = open_reg;
        grp_active_next = grp_active_reg;
        grp_tag_next    = grp_tag_reg;

        out_valid_next  = out_valid_reg && !res.ready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_client_next = out_client_reg;
        out_tag_next    = out_tag_reg;
        out_found_next  = out_found_reg;
        out_cc_next     = out_cc_reg;
        out_tc_next     = out_tc_reg;
        out_eog_next    = out_eog_reg;

        ctl            = '0;
        ctl.grp_active = grp_active_reg;
        ctl.grp_tag    = grp_tag_reg;
        ctl.client     = client_reg;
        ctl.ident      = ident_reg;
        ctl.batch      = next_batch_reg;
        ctl.timeout    = timeout_reg;

        if (open_reg != ST_OK)
            st_new = open_reg;
        else if (|idhit_v)
            st_new = ST_DUP;
        else if (int'(used_cnt) >= MAX_PER_CLIENT || !free_chain[NUM_ENTRIES])
            st_new = ST_TOO_MANY;
        else
            st_new = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // a waiting result keeps its fields
                if (out_free)
                begin
                    out_kind_next   = KIND_ADD;
                    out_status_next = ST_OK;
                    out_id_next     = ident_reg;
                    out_client_next = client_reg;
                    out_tag_next    = 16'd0;
                    out_found_next  = 1'b0;
                    out_cc_next     = 6'd0;
                    out_tc_next     = 6'd0;
                    out_eog_next    = 1'b0;
                end
                unique case (mode_reg)
                    MODE_ADD:
                    begin
                        if (!last_reg || out_free)
                        begin
                            state_next    = S_IDLE;
                            ctl.alloc     = (open_reg == ST_OK) && (st_new == ST_OK);
                            ctl.drop_tent = (st_new != ST_OK);
                            if (last_reg)
                            begin
                                ctl.commit      = (st_new == ST_OK);
                                out_valid_next  = 1'b1;
                                out_kind_next   = KIND_ADD;
                                out_status_next = st_new;
                                out_tag_next    = next_batch_reg;
                                open_next       = ST_OK;
                                if (st_new == ST_OK)
                                    next_batch_next = next_batch_reg + 16'd1;
                            end
                            else
                                open_next = st_new;
                        end
                    end
                    MODE_FINISH:
                    begin
                        if (out_free)
                        begin
                            state_next     = S_IDLE;
                            ctl.find       = 1'b1;
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_FINISH;
                            out_found_next = |phit_v;
                        end
                    end
                    MODE_TICK:
                    begin
                        state_next      = S_DRAIN;
                        ctl.tick        = 1'b1;
                        grp_active_next = 1'b0;
                    end
                    MODE_QUERY:
                    begin
                        if (out_free)
                        begin
                            state_next     = S_IDLE;
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_QUERY;
                            out_found_next = |phit_v;
                            out_cc_next    = CNT_W'($countones(pown_v));
                            out_tc_next    = CNT_W'($countones(pend_v));
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DRAIN:
            begin
                if (!(|exp_v))
                begin
                    state_next      = S_IDLE;
                    grp_active_next = 1'b0;
                end
                else if (out_free)
                begin
                    ctl.drain       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_TIMEOUT;
                    out_status_next = ST_OK;
                    out_id_next     = sel_ident;
                    out_client_next = sel_owner;
                    out_tag_next    = sel_tag;
                    out_found_next  = 1'b0;
                    out_cc_next     = 6'd0;
                    out_tc_next     = 6'd0;
                    out_eog_next    = eog;
                    grp_active_next = !eog;
                    grp_tag_next    = sel_tag;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_batch_reg <= 16'd0;
            open_reg       <= ST_OK;
            grp_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_batch_reg <= next_batch_next;
            open_reg       <= open_next;
            grp_active_reg <= grp_active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_tag_reg    <= grp_tag_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_client_reg <= out_client_next;
        out_tag_reg    <= out_tag_next;
        out_found_reg  <= out_found_next;
        out_cc_reg     <= out_cc_next;
        out_tc_reg     <= out_tc_next;
        out_eog_reg    <= out_eog_next;
        if (req.valid && state_reg == S_IDLE)
        begin
            mode_reg   <= mode_t'(req.mode);
            client_reg <= req.client;
            ident_reg  <= req.request_id;
            last_reg   <= req.last;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = out_kind_reg;
    assign res.status         = out_status_reg;
    assign res.request_id_res = out_id_reg;
    assign res.client_res     = out_client_reg;
    assign res.batch_tag      = out_tag_reg;
    assign res.found          = out_found_reg;
    assign res.client_count   = out_cc_reg;
    assign res.total_count    = out_tc_reg;
    assign res.end_of_group   = out_eog_reg;

endmodule

### hw/rtl/prtt_checker.sv
// Port-level assertions for the tracker, bound to the top level.
module prtt_checker
    import prtt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_kind,
    input logic [1:0]  res_status,
    input logic [63:0] res_id,
    input logic [5:0]  res_cc,
    input logic [5:0]  res_tc
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_id))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_ADD |-> res_status <= ST_TOO_MANY)
        else $error("undefined add status");

    a_counts_query_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_QUERY |-> res_cc == 6'd0 && res_tc == 6'd0)
        else $error("counts on non-query result");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_QUERY |-> res_cc <= res_tc)
        else $error("client count exceeds total");

endmodule

bind pending_request_timeout_tracker_unit prtt_checker u_prtt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_kind   (res.kind),
    .res_status (res.status),
    .res_id     (res.request_id_res),
    .res_cc     (res.client_count),
    .res_tc     (res.total_count)
);
